// ===== hw/rtl/maa_pkg.sv =====
// Package: constants, types and helper functions for the MAA authenticator.
package maa_pkg;

    localparam logic [31:0] MSB32            = 32'h8000_0000;
    localparam logic [31:0] MASK_A           = 32'h0204_0801;
    localparam logic [31:0] MASK_B           = 32'h0080_4021;
    localparam logic [31:0] MASK_C           = 32'hBFEF_7FDF;
    localparam logic [31:0] MASK_D           = 32'h7DFE_FBFF;
    localparam logic [31:0] KEY_FIRST_RESET  = 32'h1234_5678;
    localparam logic [31:0] KEY_SECOND_RESET = 32'h8765_4321;

    // Configuration register indexes
    localparam logic CFG_KEY_FIRST  = 1'b0;
    localparam logic CFG_KEY_SECOND = 1'b1;

    // Reduction applied to a product
    typedef enum logic [1:0] {
        RED_M1  = 2'd0,
        RED_M2  = 2'd1,
        RED_M2A = 2'd2
    } red_mode_t;

    // Request from sequencer to the shared multiplier
    typedef struct packed {
        logic        start;
        red_mode_t   mode;
        logic [31:0] op_a;
        logic [31:0] op_b;
    } mul_req_t;

    // Result from the shared multiplier
    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } mul_rsp_t;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } cond_out_t;

    // Replace 0x00 and 0xFF bytes, most significant byte of hi first
    function automatic cond_out_t condition(input logic [31:0] hi, input logic [31:0] lo);
        logic [7:0]  by [8];
        logic [7:0]  p;
        cond_out_t   r;
        for (int i = 0; i < 4; i++) begin
            by[i]   = hi[31 - 8 * i -: 8];
            by[i+4] = lo[31 - 8 * i -: 8];
        end
        p = 8'd0;
        for (int i = 0; i < 8; i++) begin
            p = {p[6:0], 1'b0};
            if (by[i] == 8'h00) begin
                p = p + 8'd1;
                by[i] = p;
            end else if (by[i] == 8'hFF) begin
                p = p + 8'd1;
                by[i] = 8'hFF - p;
            end
        end
        r.hi = {by[0], by[1], by[2], by[3]};
        r.lo = {by[4], by[5], by[6], by[7]};
        return r;
    endfunction

    // Byte pattern of the key conditioning
    function automatic logic [7:0] cond_pattern(input logic [31:0] hi, input logic [31:0] lo);
        logic [7:0]  by [8];
        logic [7:0]  p;
        for (int i = 0; i < 4; i++) begin
            by[i]   = hi[31 - 8 * i -: 8];
            by[i+4] = lo[31 - 8 * i -: 8];
        end
        p = 8'd0;
        for (int i = 0; i < 8; i++) begin
            p = {p[6:0], 1'b0};
            if (by[i] == 8'h00 || by[i] == 8'hFF) begin
                p = p + 8'd1;
            end
        end
        return p;
    endfunction

endpackage

// ===== hw/rtl/maa_mulmod.sv =====
// Shared 32x32 multiplier with end-around reductions modulo 2^32-1 and 2^32-2.
module maa_mulmod
    import maa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0] prod_reg;
    logic [63:0] prod_next;
    red_mode_t   mode_reg;
    logic        busy_reg;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] s1;
    logic [31:0] d;
    logic [32:0] sum2;
    logic [31:0] s2;
    logic [31:0] result;

    assign prod_next = 64'(req.op_a) * 64'(req.op_b);
    assign hi = prod_reg[63:32];
    assign lo = prod_reg[31:0];

    // Reduce the registered product
    always_comb
    begin
        s1 = hi + lo;
        if (s1 < hi)
        begin
            s1 = s1 + 32'd1;
        end
        d = {hi[30:0], 1'b0};
        if (mode_reg == RED_M2 && (hi & MSB32) != 32'd0)
        begin
            d = d + 32'd2;
        end
        sum2 = 33'(d) + 33'(lo);
        s2   = sum2[31:0];
        if (sum2[32])
        begin
            s2 = s2 + 32'd2;
        end
        case (mode_reg)
            RED_M1:  result = s1;
            RED_M2:  result = s2;
            RED_M2A: result = s2;
            default: result = s1;
        endcase
    end

    // Register the product and reduction mode of each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= RED_M1;
        end
        else
        begin
            busy_reg <= req.start;
            if (req.start)
            begin
                mode_reg <= req.mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_reg <= prod_next;
        end
    end

    assign rsp.done  = busy_reg;
    assign rsp.value = result;

endmodule

// ===== hw/rtl/maa_message_authenticator.sv =====
// Top level: MAA message authenticator with key registers and round sequencer.
// Each multiply runs on the single shared multiplier as an issue step and a reduce step.
// A non-last word runs a round setup plus two multiplies.
// The first word of a message adds the prelude: 19 multiplies plus a conditioning step.
// A last word adds two coda rounds and an output step; one word at a time.
// Reset (rst_n low, asynchronous) drops any partial message and restores the keys.
module maa_message_authenticator
    import maa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] mac_value
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_ISSUE,
        ST_PRE_WAIT,
        ST_PRE_FIN,
        ST_RND_SETUP,
        ST_RND_X,
        ST_RND_XW,
        ST_RND_Y,
        ST_RND_YW,
        ST_OUT
    } state_t;

    state_t      state_reg;
    logic [4:0]  step_reg;
    logic [1:0]  phase_reg;   // 0 message word, 1 coda S, 2 coda T
    logic        last_reg;
    logic        in_msg_reg;
    logic [31:0] word_reg;
    logic [31:0] key1_reg;
    logic [31:0] key2_reg;
    logic [31:0] x_reg, y_reg, v_reg, w_reg, s_reg, t_reg;
    logic [31:0] f_reg, g_reg;
    logic [31:0] j_reg, k_reg, q_reg;
    logic [31:0] j12_reg, j22_reg, j14_reg, j24_reg, j16_reg, j26_reg, j18_reg;
    logic [31:0] k12_reg, k22_reg, k14_reg, k24_reg, k15_reg, k25_reg;
    logic [31:0] k17_reg, k27_reg, k19_reg, h0_reg;
    logic [31:0] mac_reg;
    logic        out_valid_reg;

    mul_req_t    req;
    mul_rsp_t    rsp;
    cond_out_t   kc;
    logic [7:0]  kp;
    logic [8:0]  p1;
    logic [31:0] rv;
    logic [31:0] e;
    logic [31:0] xm;
    logic [31:0] ym;
    logic [31:0] word_sel;

    maa_mulmod u_mul (
        .clk (clk),
        .rst_n (rst_n),
        .req (req),
        .rsp (rsp)
    );

    assign kc = condition(key1_reg, key2_reg);
    assign kp = cond_pattern(key1_reg, key2_reg);
    assign p1 = 9'(kp) + 9'd1;

    assign s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = mac_reg;

    // Round word mixing
    always_comb
    begin
        case (phase_reg)
            2'd0:    word_sel = word_reg;
            2'd1:    word_sel = s_reg;
            default: word_sel = t_reg;
        endcase
        rv = {v_reg[30:0], v_reg[31]};
        e  = rv ^ w_reg;
        xm = x_reg ^ word_sel;
        ym = y_reg ^ word_sel;
    end

    // Multiply schedule for the prelude and the round multiplies
    always_comb
    begin
        req.start = 1'b0;
        req.mode  = RED_M1;
        req.op_a  = 32'd0;
        req.op_b  = 32'd0;
        case (state_reg)
            ST_PRE_ISSUE:
            begin
                req.start = 1'b1;
                case (step_reg)
                    5'd0:  begin req.mode = RED_M1; req.op_a = j_reg;   req.op_b = j_reg;   end
                    5'd1:  begin req.mode = RED_M2; req.op_a = j_reg;   req.op_b = j_reg;   end
                    5'd2:  begin req.mode = RED_M1; req.op_a = j12_reg; req.op_b = j12_reg; end
                    5'd3:  begin req.mode = RED_M2; req.op_a = j22_reg; req.op_b = j22_reg; end
                    5'd4:  begin req.mode = RED_M1; req.op_a = j12_reg; req.op_b = j14_reg; end
                    5'd5:  begin req.mode = RED_M2; req.op_a = j22_reg; req.op_b = j24_reg; end
                    5'd6:  begin req.mode = RED_M1; req.op_a = j12_reg; req.op_b = j16_reg; end
                    5'd7:  begin req.mode = RED_M2; req.op_a = j22_reg; req.op_b = j26_reg; end
                    5'd8:  begin req.mode = RED_M1; req.op_a = k_reg;   req.op_b = k_reg;   end
                    5'd9:  begin req.mode = RED_M2; req.op_a = k_reg;   req.op_b = k_reg;   end
                    5'd10: begin req.mode = RED_M1; req.op_a = k12_reg; req.op_b = k12_reg; end
                    5'd11: begin req.mode = RED_M2; req.op_a = k22_reg; req.op_b = k22_reg; end
                    5'd12: begin req.mode = RED_M1; req.op_a = k_reg;   req.op_b = k14_reg; end
                    5'd13: begin req.mode = RED_M2; req.op_a = k_reg;   req.op_b = k24_reg; end
                    5'd14: begin req.mode = RED_M1; req.op_a = k12_reg; req.op_b = k15_reg; end
                    5'd15: begin req.mode = RED_M2; req.op_a = k22_reg; req.op_b = k25_reg; end
                    5'd16: begin req.mode = RED_M1; req.op_a = k12_reg; req.op_b = k17_reg; end
                    5'd17: begin req.mode = RED_M2; req.op_a = k22_reg; req.op_b = k27_reg; end
                    default:
                    begin
                        req.mode = RED_M2; req.op_a = h0_reg; req.op_b = q_reg;
                    end
                endcase
            end
            ST_RND_X:
            begin
                req.start = 1'b1;
                req.mode  = RED_M1;
                req.op_a  = x_reg;
                req.op_b  = f_reg;
            end
            ST_RND_Y:
            begin
                req.start = 1'b1;
                req.mode  = RED_M2A;
                req.op_a  = y_reg;
                req.op_b  = g_reg;
            end
            default:
            begin
                req.start = 1'b0;
            end
        endcase
    end

    // Sequencer, key registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 5'd0;
            phase_reg     <= 2'd0;
            last_reg      <= 1'b0;
            in_msg_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            key1_reg      <= KEY_FIRST_RESET;
            key2_reg      <= KEY_SECOND_RESET;
            x_reg         <= 32'd0;
            y_reg         <= 32'd0;
            v_reg         <= 32'd0;
            w_reg         <= 32'd0;
            s_reg         <= 32'd0;
            t_reg         <= 32'd0;
        end
        else
        begin
            // Take a key write
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_KEY_FIRST:  key1_reg <= cfg_data;
                    CFG_KEY_SECOND: key2_reg <= cfg_data;
                    default:        key1_reg <= key1_reg;
                endcase
            end
            // Drop output once taken
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        word_reg  <= s_axis_tdata;
                        last_reg  <= s_axis_tlast;
                        phase_reg <= 2'd0;
                        if (!in_msg_reg)
                        begin
                            j_reg     <= kc.hi;
                            k_reg     <= kc.lo;
                            q_reg     <= 32'(p1) * 32'(p1);
                            step_reg  <= 5'd0;
                            state_reg <= ST_PRE_ISSUE;
                        end
                        else
                        begin
                            state_reg <= ST_RND_SETUP;
                        end
                    end
                end
                ST_PRE_ISSUE:
                begin
                    state_reg <= ST_PRE_WAIT;
                end
                ST_PRE_WAIT:
                begin
                    case (step_reg)
                        5'd0:  j12_reg <= rsp.value;
                        5'd1:  j22_reg <= rsp.value;
                        5'd2:  j14_reg <= rsp.value;
                        5'd3:  j24_reg <= rsp.value;
                        5'd4:  j16_reg <= rsp.value;
                        5'd5:  j26_reg <= rsp.value;
                        5'd6:  j18_reg <= rsp.value;
                        5'd7:
                        begin
                            // j28 ready: fold h4, h6, h8 into the J pairs
                            j14_reg <= j14_reg ^ j24_reg;
                            j16_reg <= j16_reg ^ j26_reg;
                            j18_reg <= j18_reg ^ rsp.value;
                        end
                        5'd8:  k12_reg <= rsp.value;
                        5'd9:  k22_reg <= rsp.value;
                        5'd10: k14_reg <= rsp.value;
                        5'd11: k24_reg <= rsp.value;
                        5'd12: k15_reg <= rsp.value;
                        5'd13:
                        begin
                            k25_reg <= rsp.value;
                            h0_reg  <= k15_reg ^ rsp.value;
                        end
                        5'd14: k17_reg <= rsp.value;
                        5'd15: k27_reg <= rsp.value;
                        5'd16: k19_reg <= rsp.value;
                        5'd17:
                        begin
                            k19_reg <= k19_reg ^ rsp.value;
                            k17_reg <= k17_reg ^ k27_reg;
                        end
                        default: h0_reg <= rsp.value;
                    endcase
                    if (step_reg == 5'd18)
                    begin
                        state_reg <= ST_PRE_FIN;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= ST_PRE_ISSUE;
                    end
                end
                ST_PRE_FIN:
                begin
                    // h4 in j14, h5 in h0, h6 in j16, h7 in k17, h8 in j18, h9 in k19
                    x_reg      <= condition(j14_reg, h0_reg).hi;
                    y_reg      <= condition(j14_reg, h0_reg).lo;
                    v_reg      <= condition(j16_reg, k17_reg).hi;
                    w_reg      <= condition(j16_reg, k17_reg).lo;
                    s_reg      <= condition(j18_reg, k19_reg).hi;
                    t_reg      <= condition(j18_reg, k19_reg).lo;
                    in_msg_reg <= 1'b1;
                    state_reg  <= ST_RND_SETUP;
                end
                ST_RND_SETUP:
                begin
                    v_reg     <= rv;
                    x_reg     <= xm;
                    y_reg     <= ym;
                    f_reg     <= ((e + ym) | MASK_A) & MASK_C;
                    g_reg     <= ((e + xm) | MASK_B) & MASK_D;
                    state_reg <= ST_RND_X;
                end
                ST_RND_X:
                begin
                    state_reg <= ST_RND_XW;
                end
                ST_RND_XW:
                begin
                    x_reg     <= rsp.value;
                    state_reg <= ST_RND_Y;
                end
                ST_RND_Y:
                begin
                    state_reg <= ST_RND_YW;
                end
                ST_RND_YW:
                begin
                    y_reg <= rsp.value;
                    if (!last_reg || phase_reg == 2'd2)
                    begin
                        state_reg <= last_reg ? ST_OUT : ST_IDLE;
                    end
                    else
                    begin
                        phase_reg <= phase_reg + 2'd1;
                        state_reg <= ST_RND_SETUP;
                    end
                end
                ST_OUT:
                begin
                    mac_reg       <= x_reg ^ y_reg;
                    out_valid_reg <= 1'b1;
                    in_msg_reg    <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A result is only produced from the output step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output step");

    // Multiplier answers in the cycle after each request
    assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> rsp.done)
        else $error("multiplier response missing");

    // Input is never taken while the sequencer is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");

    // Prelude step counter stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRE_ISSUE) |-> (step_reg <= 5'd18))
        else $error("prelude step out of range");

endmodule

// ===== tb/maa_message_authenticator_tb.sv =====
// Testbench for the MAA message authenticator, checked against a behavioral MAC predictor.
`timescale 1ns / 1ps

module maa_message_authenticator_tb
    import maa_pkg::*;
;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } word_req_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    word_req_t   pending_words[$];
    logic [31:0] expected_macs[$];
    int          error_count;
    int          cycle_count;
    bit          calm_mode;
    bit          send_pause;
    bit          src_taken;
    int          sink_hold;
    int          src_gap;
    int          sink_gap;

    // Predictor state
    logic [31:0] pk_first, pk_second;
    logic [31:0] px, py, pv, pw, ps, pt;
    bit          p_busy;

    maa_message_authenticator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Product modulo 2^32-1
    function automatic logic [31:0] mul_m1(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        logic [32:0] s;
        p = a * b;
        s = p[63:32] + p[31:0];
        return s[32] ? s[31:0] + 32'd1 : s[31:0];
    endfunction

    // Product modulo 2^32-2; fold_msb selects the full variant
    function automatic logic [31:0] mul_m2(input logic [31:0] a, input logic [31:0] b,
                                           input bit fold_msb);
        logic [63:0] p;
        logic [31:0] d;
        logic [32:0] s;
        p = a * b;
        d = {p[62:32], 1'b0};
        if (fold_msb && p[63])
            d = d + 32'd2;
        s = d + p[31:0];
        return s[32] ? s[31:0] + 32'd2 : s[31:0];
    endfunction

    // Replace zero and all-ones key bytes; returns {hi, lo, pattern}
    function automatic logic [71:0] fix_bytes(input logic [31:0] hi, input logic [31:0] lo);
        logic [63:0] all;
        logic [7:0]  b;
        logic [7:0]  pat;
        all = {hi, lo};
        pat = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            b = all[63 - 8 * i -: 8];
            pat = {pat[6:0], 1'b0};
            if (b == 8'h00)
            begin
                pat = pat + 8'd1;
                all[63 - 8 * i -: 8] = pat;
            end
            else if (b == 8'hFF)
            begin
                pat = pat + 8'd1;
                all[63 - 8 * i -: 8] = 8'hFF - pat;
            end
        end
        return {all, pat};
    endfunction

    // Derive the message state from the current key
    task automatic key_prelude();
        logic [71:0] c;
        logic [31:0] j, k, q;
        logic [31:0] j12, j22, j14, j24, j16, j26, j18, j28;
        logic [31:0] k12, k22, k14, k24, k15, k25, k17, k27, k19, k29;
        logic [31:0] h0, h4, h5, h6, h7, h8, h9;
        c = fix_bytes(pk_first, pk_second);
        j = c[71:40];
        k = c[39:8];
        q = (32'(c[7:0]) + 32'd1) * (32'(c[7:0]) + 32'd1);
        j12 = mul_m1(j, j);     j22 = mul_m2(j, j, 1);
        j14 = mul_m1(j12, j12); j24 = mul_m2(j22, j22, 1);
        j16 = mul_m1(j12, j14); j26 = mul_m2(j22, j24, 1);
        j18 = mul_m1(j12, j16); j28 = mul_m2(j22, j26, 1);
        h4 = j14 ^ j24;
        h6 = j16 ^ j26;
        h8 = j18 ^ j28;
        k12 = mul_m1(k, k);     k22 = mul_m2(k, k, 1);
        k14 = mul_m1(k12, k12); k24 = mul_m2(k22, k22, 1);
        k15 = mul_m1(k, k14);   k25 = mul_m2(k, k24, 1);
        k17 = mul_m1(k12, k15); k27 = mul_m2(k22, k25, 1);
        k19 = mul_m1(k12, k17); k29 = mul_m2(k22, k27, 1);
        h0 = k15 ^ k25;
        h5 = mul_m2(h0, q, 1);
        h7 = k17 ^ k27;
        h9 = k19 ^ k29;
        c = fix_bytes(h4, h5); px = c[71:40]; py = c[39:8];
        c = fix_bytes(h6, h7); pv = c[71:40]; pw = c[39:8];
        c = fix_bytes(h8, h9); ps = c[71:40]; pt = c[39:8];
    endtask

    task automatic mac_round(input logic [31:0] m);
        logic [31:0] e, f, g;
        pv = {pv[30:0], pv[31]};
        e = pv ^ pw;
        px = px ^ m;
        py = py ^ m;
        f = ((e + py) | MASK_A) & MASK_C;
        g = ((e + px) | MASK_B) & MASK_D;
        px = mul_m1(px, f);
        py = mul_m2(py, g, 0);
    endtask

    // Advance the predictor by one accepted word
    task automatic predict_word(input logic [31:0] word, input logic last);
        if (!p_busy)
        begin
            key_prelude();
            p_busy = 1;
        end
        mac_round(word);
        if (last)
        begin
            mac_round(ps);
            mac_round(pt);
            p_busy = 0;
            expected_macs.push_back(px ^ py);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %08h expected %08h at cycle %0d",
                 what, got, want, cycle_count);
        error_count++;
    endtask

    // Note each accepted request at the clock edge
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            src_taken = 1'b1;
    end

    // Drive message words from the pending queue
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (src_gap > 0)
                src_gap--;
            if (src_taken)
            begin
                src_taken = 1'b0;
                predict_word(s_axis_tdata, s_axis_tlast);
                void'(pending_words.pop_front());
                if (!calm_mode && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 7);
            end
            if (pending_words.size() > 0 && src_gap == 0 && !send_pause)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_words[0].word;
                s_axis_tlast  <= pending_words[0].last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receive and check MAC results
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_macs.size() == 0)
                report_mismatch("unexpected mac", m_axis_tdata, 32'h0);
            else
            begin
                if (m_axis_tdata !== expected_macs[0])
                    report_mismatch("mac_value", m_axis_tdata, expected_macs[0]);
                void'(expected_macs.pop_front());
            end
        end
    end

    // Sink backpressure: random bursts plus an optional long hold
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_axis_tready <= 1'b0;
        end
        else if (!calm_mode && $urandom_range(0, 5) == 0)
        begin
            sink_gap = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_message(input int len, input bit random_words);
        word_req_t r;
        for (int i = 0; i < len; i++)
        begin
            r.word = random_words ? $urandom() : 32'h0;
            r.last = (i == len - 1);
            pending_words.push_back(r);
        end
    endtask

    task automatic push_word(input logic [31:0] w, input logic l);
        word_req_t r;
        r.word = w;
        r.last = l;
        pending_words.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_macs.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_key(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_KEY_FIRST)
            pk_first = value;
        else
            pk_second = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int len;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 32'h0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_KEY_FIRST;
        cfg_data = 32'h0;
        error_count = 0;
        cycle_count = 0;
        calm_mode = 0;
        send_pause = 0;
        src_taken = 0;
        sink_hold = 0;
        src_gap = 0;
        sink_gap = 0;
        pk_first = KEY_FIRST_RESET;
        pk_second = KEY_SECOND_RESET;
        p_busy = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset key, single-word and multi-word messages, field extremes
        push_word(32'h0000_0000, 1'b1);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'h8000_0001, 1'b1);
        push_word(32'h5555_5555, 1'b0);
        push_word(32'hAAAA_AAAA, 1'b1);
        wait_drained();

        // Key extremes: all-zero and all-ones keys exercise byte conditioning
        write_key(CFG_KEY_FIRST, 32'h0000_0000);
        write_key(CFG_KEY_SECOND, 32'h0000_0000);
        push_word(32'h0000_0000, 1'b1);
        push_word(32'h1234_5678, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);
        wait_drained();
        write_key(CFG_KEY_FIRST, 32'hFFFF_FFFF);
        write_key(CFG_KEY_SECOND, 32'hFFFF_FFFF);
        push_word(32'hFFFF_FFFF, 1'b1);
        push_word(32'h0000_0000, 1'b1);
        wait_drained();
        write_key(CFG_KEY_FIRST, 32'h00FF_00FF);
        write_key(CFG_KEY_SECOND, 32'hFF00_FF00);
        queue_message(3, 1);
        wait_drained();

        // Long sink hold while the source keeps offering words
        sink_hold = 400;
        for (int i = 0; i < 10; i++)
            queue_message($urandom_range(1, 3), 1);
        wait_drained();

        // Random messages across several keys
        for (int phase = 0; phase < 6; phase++)
        begin
            write_key(CFG_KEY_FIRST, $urandom());
            write_key(CFG_KEY_SECOND, $urandom());
            if (phase == 5)
                calm_mode = 1;
            for (int n = 0; n < 25; n++)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16)
                                                  : $urandom_range(1, 5);
                queue_message(len, 1);
            end
            // Source pause until every MAC has arrived
            if (phase == 2)
            begin
                while (pending_words.size() > 0)
                    @(posedge clk);
                send_pause = 1;
                while (expected_macs.size() > 0 || s_axis_tvalid)
                    @(posedge clk);
                send_pause = 0;
            end
            wait_drained();
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
